>>> sv/lts_pkg.sv
// lts_pkg: shared constants and codes of the lisp token scanner
package lts_pkg;

	// default widths of the position, line and length counters
	localparam int POSITION_BITS_DEF = 32;
	localparam int LINE_BITS_DEF     = 24;
	localparam int LENGTH_BITS_DEF   = 16;

	// result queue sizing: one byte can give up to three tokens
	localparam int MAX_RESULTS = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int PUSH_W      = $clog2(MAX_RESULTS + 1);

	localparam int KIND_W = 4;

	// token kinds
	localparam logic [KIND_W-1:0] K_EOF    = 4'd0;
	localparam logic [KIND_W-1:0] K_LPAREN = 4'd1;
	localparam logic [KIND_W-1:0] K_RPAREN = 4'd2;
	localparam logic [KIND_W-1:0] K_QUOTE  = 4'd3;
	localparam logic [KIND_W-1:0] K_DOT    = 4'd4;
	localparam logic [KIND_W-1:0] K_NUMBER = 4'd5;
	localparam logic [KIND_W-1:0] K_IDENT  = 4'd6;
	localparam logic [KIND_W-1:0] K_CAR    = 4'd7;
	localparam logic [KIND_W-1:0] K_CDR    = 4'd8;
	localparam logic [KIND_W-1:0] K_CONS   = 4'd9;
	localparam logic [KIND_W-1:0] K_DEFINE = 4'd10;
	localparam logic [KIND_W-1:0] K_LAMBDA = 4'd11;
	localparam logic [KIND_W-1:0] K_ERROR  = 4'd12;

	// special bytes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DIG_LO = 8'h30;
	localparam logic [7:0] CH_DIG_HI = 8'h39;
	localparam logic [7:0] CH_PRT_LO = 8'h21;
	localparam logic [7:0] CH_PRT_HI = 8'h7E;

	// keyword spellings, first byte in the most significant position
	localparam int          KW_BITS   = 48;
	localparam logic [23:0] KW_CAR    = 24'h636172;
	localparam logic [23:0] KW_CDR    = 24'h636472;
	localparam logic [31:0] KW_CONS   = 32'h636F6E73;
	localparam logic [47:0] KW_DEFINE = 48'h646566696E65;
	localparam logic [47:0] KW_LAMBDA = 48'h6C616D626461;
	localparam logic [39:0] KW_QUOTEW = 40'h71756F7465;

endpackage

>>> sv/lts_scanner.sv
// lts_scanner: input register, scan state and per-byte token decode
module lts_scanner #(
	parameter int POSITION_BITS = lts_pkg::POSITION_BITS_DEF,
	parameter int LINE_BITS     = lts_pkg::LINE_BITS_DEF,
	parameter int LENGTH_BITS   = lts_pkg::LENGTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     src_byte,
	input  logic                           room,
	output logic [lts_pkg::PUSH_W-1:0]     push_n,
	output logic [lts_pkg::KIND_W-1:0]     r_kind  [lts_pkg::MAX_RESULTS],
	output logic [POSITION_BITS-1:0]       r_start [lts_pkg::MAX_RESULTS],
	output logic [LENGTH_BITS-1:0]         r_len   [lts_pkg::MAX_RESULTS],
	output logic [LINE_BITS-1:0]           r_line  [lts_pkg::MAX_RESULTS],
	output logic                           r_last  [lts_pkg::MAX_RESULTS]
);

	localparam int P  = POSITION_BITS;
	localparam int W  = (POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS;
	localparam int KB = lts_pkg::KW_BITS;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_INT     = 3'd2;
	localparam logic [2:0] MODE_DOT     = 3'd3;
	localparam logic [2:0] MODE_FRAC    = 3'd4;
	localparam logic [2:0] MODE_IDENT   = 3'd5;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  fire;

	logic [2:0]            mode_q, mode_d;
	logic [P-1:0]          pos_q, pos_d;
	logic [LINE_BITS-1:0]  line_q, line_d, line_inc;
	logic [P-1:0]          begin_q, begin_d;
	logic [KB-1:0]         prefix_q, prefix_d;
	logic [5:0]            alive_q, alive_d;

	logic                  digit_hit, is_ident;
	logic [P-1:0]          dot_pos;
	logic [LENGTH_BITS-1:0] len_cur, len_dot;
	logic [lts_pkg::KIND_W-1:0] id_kind;
	logic [1:0]            n;
	logic                  at_start;

	// saturate a position difference into the length field
	function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [P-1:0] d);
		logic [W-1:0] dw;
		dw = W'(d);
		if (dw > W'({LENGTH_BITS{1'b1}}))
			sat_len = {LENGTH_BITS{1'b1}};
		else
			sat_len = dw[LENGTH_BITS-1:0];
	endfunction

	// input register: one word held until the queue has room
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= src_byte;
		end
	end

	// byte classes
	assign digit_hit = (byte_s1 >= lts_pkg::CH_DIG_LO) && (byte_s1 <= lts_pkg::CH_DIG_HI);
	assign is_ident = (byte_s1 >= lts_pkg::CH_PRT_LO) && (byte_s1 <= lts_pkg::CH_PRT_HI)
		&& (byte_s1 != lts_pkg::CH_LPAREN) && (byte_s1 != lts_pkg::CH_RPAREN)
		&& (byte_s1 != lts_pkg::CH_QUOTE) && (byte_s1 != lts_pkg::CH_DOT);

	// token lengths and the held dot position
	assign dot_pos  = (pos_q > begin_q) ? pos_q - P'(1) : begin_q;
	assign len_cur  = sat_len(pos_q - begin_q);
	assign len_dot  = sat_len(dot_pos - begin_q);
	assign line_inc = (line_q != {LINE_BITS{1'b1}}) ? line_q + LINE_BITS'(1) : line_q;

	// keyword match on the identifier collected so far
	always_comb begin
		id_kind = lts_pkg::K_IDENT;
		if (alive_q == 6'd3 && prefix_q[23:0] == lts_pkg::KW_CAR)
			id_kind = lts_pkg::K_CAR;
		else if (alive_q == 6'd3 && prefix_q[23:0] == lts_pkg::KW_CDR)
			id_kind = lts_pkg::K_CDR;
		else if (alive_q == 6'd4 && prefix_q[31:0] == lts_pkg::KW_CONS)
			id_kind = lts_pkg::K_CONS;
		else if (alive_q == 6'd6 && prefix_q == lts_pkg::KW_DEFINE)
			id_kind = lts_pkg::K_DEFINE;
		else if (alive_q == 6'd6 && prefix_q == lts_pkg::KW_LAMBDA)
			id_kind = lts_pkg::K_LAMBDA;
		else if (alive_q == 6'd5 && prefix_q[39:0] == lts_pkg::KW_QUOTEW)
			id_kind = lts_pkg::K_QUOTE;
	end

	// mode update and token emission for the held byte
	always_comb begin
		mode_d   = mode_q;
		pos_d    = (pos_q != {P{1'b1}}) ? pos_q + P'(1) : pos_q;
		line_d   = line_q;
		begin_d  = begin_q;
		prefix_d = prefix_q;
		alive_d  = alive_q;
		n        = 2'd0;
		at_start = 1'b0;
		for (int i = 0; i < lts_pkg::MAX_RESULTS; i++) begin
			r_kind[i]  = lts_pkg::K_EOF;
			r_start[i] = '0;
			r_len[i]   = '0;
			r_line[i]  = line_q;
			r_last[i]  = 1'b0;
		end

		unique case (mode_q)
			MODE_COMMENT: begin
				if (byte_s1 == lts_pkg::CH_LF) begin
					line_d = line_inc;
					mode_d = MODE_IDLE;
				end else if (byte_s1 == lts_pkg::CH_NUL) begin
					at_start = 1'b1;
				end
			end
			MODE_INT: begin
				if (digit_hit) begin
					mode_d = MODE_INT;
				end else if (byte_s1 == lts_pkg::CH_DOT) begin
					mode_d = MODE_DOT;
				end else begin
					r_kind[n]  = lts_pkg::K_NUMBER;
					r_start[n] = begin_q;
					r_len[n]   = len_cur;
					n          = n + 2'd1;
					at_start   = 1'b1;
				end
			end
			MODE_DOT: begin
				if (digit_hit) begin
					mode_d = MODE_FRAC;
				end else begin
					r_kind[n]  = lts_pkg::K_NUMBER;
					r_start[n] = begin_q;
					r_len[n]   = len_dot;
					n          = n + 2'd1;
					r_kind[n]  = lts_pkg::K_DOT;
					r_start[n] = dot_pos;
					r_len[n]   = LENGTH_BITS'(1);
					n          = n + 2'd1;
					at_start   = 1'b1;
				end
			end
			MODE_FRAC: begin
				if (!digit_hit) begin
					r_kind[n]  = lts_pkg::K_NUMBER;
					r_start[n] = begin_q;
					r_len[n]   = len_cur;
					n          = n + 2'd1;
					at_start   = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (is_ident) begin
					prefix_d = {prefix_q[KB-9:0], byte_s1};
					alive_d  = (alive_q != 6'd63) ? alive_q + 6'd1 : alive_q;
				end else begin
					r_kind[n]  = id_kind;
					r_start[n] = begin_q;
					r_len[n]   = len_cur;
					n          = n + 2'd1;
					at_start   = 1'b1;
				end
			end
			default: begin
				at_start = 1'b1;
			end
		endcase

		// byte handled as at the start of a token
		if (at_start) begin
			mode_d = MODE_IDLE;
			if (byte_s1 == lts_pkg::CH_NUL) begin
				r_kind[n]  = lts_pkg::K_EOF;
				r_start[n] = pos_q;
				r_len[n]   = '0;
				n          = n + 2'd1;
				pos_d      = '0;
				line_d     = LINE_BITS'(1);
				begin_d    = '0;
				prefix_d   = '0;
				alive_d    = '0;
			end else if (byte_s1 == lts_pkg::CH_LF) begin
				line_d = line_inc;
			end else if (byte_s1 == lts_pkg::CH_SPACE || byte_s1 == lts_pkg::CH_TAB
					|| byte_s1 == lts_pkg::CH_CR) begin
				mode_d = MODE_IDLE;
			end else if (byte_s1 == lts_pkg::CH_SEMI) begin
				mode_d = MODE_COMMENT;
			end else if (digit_hit) begin
				begin_d = pos_q;
				mode_d  = MODE_INT;
			end else if (is_ident) begin
				begin_d  = pos_q;
				prefix_d = KB'(byte_s1);
				alive_d  = 6'd1;
				mode_d   = MODE_IDENT;
			end else begin
				unique case (byte_s1)
					lts_pkg::CH_LPAREN: r_kind[n] = lts_pkg::K_LPAREN;
					lts_pkg::CH_RPAREN: r_kind[n] = lts_pkg::K_RPAREN;
					lts_pkg::CH_QUOTE:  r_kind[n] = lts_pkg::K_QUOTE;
					lts_pkg::CH_DOT:    r_kind[n] = lts_pkg::K_DOT;
					default:            r_kind[n] = lts_pkg::K_ERROR;
				endcase
				r_start[n] = pos_q;
				r_len[n]   = LENGTH_BITS'(1);
				n          = n + 2'd1;
			end
		end

		// flag the final token of this word
		if (n != 2'd0)
			r_last[n - 2'd1] = 1'b1;
	end

	assign push_n = fire ? lts_pkg::PUSH_W'(n) : '0;

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			line_q   <= LINE_BITS'(1);
			begin_q  <= '0;
			prefix_q <= '0;
			alive_q  <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			begin_q  <= begin_d;
			prefix_q <= prefix_d;
			alive_q  <= alive_d;
		end
	end

endmodule

>>> sv/lts_result_queue.sv
// lts_result_queue: small token queue taking up to three words a cycle, one out
module lts_result_queue #(
	parameter int POSITION_BITS = lts_pkg::POSITION_BITS_DEF,
	parameter int LINE_BITS     = lts_pkg::LINE_BITS_DEF,
	parameter int LENGTH_BITS   = lts_pkg::LENGTH_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lts_pkg::PUSH_W-1:0] push_n,
	input  logic [lts_pkg::KIND_W-1:0] r_kind  [lts_pkg::MAX_RESULTS],
	input  logic [POSITION_BITS-1:0]   r_start [lts_pkg::MAX_RESULTS],
	input  logic [LENGTH_BITS-1:0]     r_len   [lts_pkg::MAX_RESULTS],
	input  logic [LINE_BITS-1:0]       r_line  [lts_pkg::MAX_RESULTS],
	input  logic                       r_last  [lts_pkg::MAX_RESULTS],
	output logic                       room,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lts_pkg::KIND_W-1:0] token_kind,
	output logic [POSITION_BITS-1:0]   start_offset,
	output logic [LENGTH_BITS-1:0]     token_length,
	output logic [LINE_BITS-1:0]       line_number,
	output logic                       last_of_run
);

	localparam int AW = lts_pkg::QUEUE_AW;
	localparam int CW = lts_pkg::QUEUE_CW;
	localparam int D  = lts_pkg::QUEUE_DEPTH;

	logic [lts_pkg::KIND_W-1:0] kind_q  [D];
	logic [POSITION_BITS-1:0]   start_q [D];
	logic [LENGTH_BITS-1:0]     len_q   [D];
	logic [LINE_BITS-1:0]       line_q  [D];
	logic                       last_q  [D];

	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q, count_after_pop;
	logic          pop;

	// room for a full burst once this cycle's word has left
	assign pop             = out_valid && out_ready;
	assign count_after_pop = count_q - CW'(pop);
	assign room            = count_after_pop <= CW'(D - lts_pkg::MAX_RESULTS);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(push_n);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_after_pop + CW'(push_n);
		end
	end

	// token storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < lts_pkg::MAX_RESULTS; i++) begin
			if (lts_pkg::PUSH_W'(i) < push_n) begin
				kind_q[wr_q + AW'(i)]  <= r_kind[i];
				start_q[wr_q + AW'(i)] <= r_start[i];
				len_q[wr_q + AW'(i)]   <= r_len[i];
				line_q[wr_q + AW'(i)]  <= r_line[i];
				last_q[wr_q + AW'(i)]  <= r_last[i];
			end
		end
	end

	// head of queue drives the output
	assign out_valid    = count_q != '0;
	assign token_kind   = kind_q[rd_q];
	assign start_offset = start_q[rd_q];
	assign token_length = len_q[rd_q];
	assign line_number  = line_q[rd_q];
	assign last_of_run  = last_q[rd_q];

endmodule

>>> sv/lisp_token_scanner.sv
// lisp_token_scanner: top level of the byte-serial s-expression tokenizer
//
// Source text enters one byte per word on the in channel (in_valid,
// in_ready, src_byte); byte 0 ends a source, flushes any pending token,
// emits an EOF token and restarts at offset 0, line 1. Tokens leave one
// per word on the out channel (out_valid, out_ready and the token fields);
// last_of_run marks the final token caused by one input byte.
// A byte is taken every cycle while the result queue has room. It is
// held in the input register, decoded there, and its tokens (zero to
// three) are written to a four-entry queue once the queue has room; the
// first token is offered from the queue after that write. Output runs at
// one token per cycle while the receiver is ready; a byte moves on only
// while at most one token is left after this cycle's output, so with the
// receiver ready a three-token byte holds up the next byte, and over a
// run the tokens beyond one per byte slow down the input.
// When the receiver stalls the queue fills and in_ready drops; no token
// is lost. Reset empties the queue and input register and puts the
// scanner between tokens at offset 0, line 1.
module lisp_token_scanner #(
	parameter int POSITION_BITS = lts_pkg::POSITION_BITS_DEF,
	parameter int LINE_BITS     = lts_pkg::LINE_BITS_DEF,
	parameter int LENGTH_BITS   = lts_pkg::LENGTH_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 src_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lts_pkg::KIND_W-1:0] token_kind,
	output logic [POSITION_BITS-1:0]   start_offset,
	output logic [LENGTH_BITS-1:0]     token_length,
	output logic [LINE_BITS-1:0]       line_number,
	output logic                       last_of_run
);

	logic                       room;
	logic [lts_pkg::PUSH_W-1:0] push_n;
	logic [lts_pkg::KIND_W-1:0] r_kind  [lts_pkg::MAX_RESULTS];
	logic [POSITION_BITS-1:0]   r_start [lts_pkg::MAX_RESULTS];
	logic [LENGTH_BITS-1:0]     r_len   [lts_pkg::MAX_RESULTS];
	logic [LINE_BITS-1:0]       r_line  [lts_pkg::MAX_RESULTS];
	logic                       r_last  [lts_pkg::MAX_RESULTS];

	// byte decode and scan state
	lts_scanner #(
		.POSITION_BITS(POSITION_BITS),
		.LINE_BITS    (LINE_BITS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_scanner (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.src_byte(src_byte),
		.room    (room),
		.push_n  (push_n),
		.r_kind  (r_kind),
		.r_start (r_start),
		.r_len   (r_len),
		.r_line  (r_line),
		.r_last  (r_last)
	);

	// token queue and output
	lts_result_queue #(
		.POSITION_BITS(POSITION_BITS),
		.LINE_BITS    (LINE_BITS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_n      (push_n),
		.r_kind      (r_kind),
		.r_start     (r_start),
		.r_len       (r_len),
		.r_line      (r_line),
		.r_last      (r_last),
		.room        (room),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.start_offset(start_offset),
		.token_length(token_length),
		.line_number (line_number),
		.last_of_run (last_of_run)
	);

endmodule
